### hdl/itri_pkg.sv
`default_nettype none

package itri_pkg;

    // Width of every index field at the ports
    localparam int IDX_FIELD_W = 32;

    // Default number of index bits kept
    localparam int DEF_INDEX_WIDTH = 32;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_PRIM_MODE      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESTART_ENABLE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESTART_VALUE  = 2'd2;

    // Primitive modes
    localparam logic [1:0] MODE_LIST  = 2'd0;
    localparam logic [1:0] MODE_STRIP = 2'd1;
    localparam logic [1:0] MODE_FAN   = 2'd2;

    localparam logic [IDX_FIELD_W-1:0] RESTART_VALUE_RESET = '1;

    typedef struct packed {
        logic [IDX_FIELD_W-1:0] corner_a;
        logic [IDX_FIELD_W-1:0] corner_b;
        logic [IDX_FIELD_W-1:0] corner_c;
    } triangle_t;

    // One assembled triangle handed from the core to the output stage
    typedef struct packed {
        logic      valid;
        triangle_t corners;
    } result_t;

endpackage

`default_nettype wire

### hdl/itri_if.sv
`default_nettype none

interface itri_index_if
    import itri_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [IDX_FIELD_W-1:0] vertex_index;
    logic                   end_of_draw;

    modport source (output valid, output vertex_index, output end_of_draw, input ready);
    modport sink   (input valid, input vertex_index, input end_of_draw, output ready);
endinterface

interface itri_triangle_if
    import itri_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [IDX_FIELD_W-1:0] corner_a;
    logic [IDX_FIELD_W-1:0] corner_b;
    logic [IDX_FIELD_W-1:0] corner_c;

    modport source (output valid, output corner_a, output corner_b, output corner_c,
                    input ready);
    modport sink   (input valid, input corner_a, input corner_b, input corner_c,
                    output ready);
endinterface

`default_nettype wire

### hdl/itri_core.sv
`default_nettype none

module itri_core
    import itri_pkg::*;
#(
    parameter int INDEX_WIDTH = DEF_INDEX_WIDTH
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   take,
    input  wire logic [IDX_FIELD_W-1:0] vertex_index,
    input  wire logic                   end_of_draw,
    output result_t                     result
);

    logic [1:0]             prim_mode_reg;
    logic                   restart_enable_reg;
    logic [IDX_FIELD_W-1:0] restart_value_reg;

    logic [INDEX_WIDTH-1:0] older_reg, older_next;
    logic [INDEX_WIDTH-1:0] newer_reg, newer_next;
    logic [INDEX_WIDTH-1:0] centre_reg, centre_next;
    logic [1:0]             count_reg, count_next;
    logic                   parity_reg, parity_next;

    logic [INDEX_WIDTH-1:0] idx;
    logic                   restart_hit;

    assign idx         = vertex_index[INDEX_WIDTH-1:0];
    assign restart_hit = restart_enable_reg && (IDX_FIELD_W'(idx) == restart_value_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prim_mode_reg      <= MODE_LIST;
            restart_enable_reg <= 1'b0;
            restart_value_reg  <= RESTART_VALUE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PRIM_MODE:      prim_mode_reg      <= cfg_data[1:0];
                CFG_RESTART_ENABLE: restart_enable_reg <= cfg_data[0];
                CFG_RESTART_VALUE:  restart_value_reg  <= cfg_data[IDX_FIELD_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        older_next     = older_reg;
        newer_next     = newer_reg;
        centre_next    = centre_reg;
        count_next     = count_reg;
        parity_next    = parity_reg;
        result.valid   = 1'b0;
        result.corners = '0;

        case (prim_mode_reg)
            MODE_LIST:
            begin
                case (count_reg)
                    2'd0:
                    begin
                        older_next = idx;
                        count_next = 2'd1;
                    end
                    2'd1:
                    begin
                        newer_next = idx;
                        count_next = 2'd2;
                    end
                    default:
                    begin
                        result.valid            = take;
                        result.corners.corner_a = IDX_FIELD_W'(older_reg);
                        result.corners.corner_b = IDX_FIELD_W'(newer_reg);
                        result.corners.corner_c = IDX_FIELD_W'(idx);
                        count_next              = 2'd0;
                    end
                endcase
            end
            MODE_STRIP, MODE_FAN:
            begin
                if (restart_hit)
                begin
                    count_next  = 2'd0;
                    parity_next = 1'b0;
                end
                else
                begin
                    case (count_reg)
                        2'd0:
                        begin
                            centre_next = idx;
                            newer_next  = idx;
                            count_next  = 2'd1;
                        end
                        2'd1:
                        begin
                            older_next = newer_reg;
                            newer_next = idx;
                            count_next = 2'd2;
                        end
                        default:
                        begin
                            result.valid            = take;
                            result.corners.corner_a = IDX_FIELD_W'(idx);
                            if (prim_mode_reg == MODE_FAN)
                            begin
                                result.corners.corner_b = IDX_FIELD_W'(centre_reg);
                                result.corners.corner_c = IDX_FIELD_W'(newer_reg);
                            end
                            else if (parity_reg)
                            begin
                                result.corners.corner_b = IDX_FIELD_W'(newer_reg);
                                result.corners.corner_c = IDX_FIELD_W'(older_reg);
                            end
                            else
                            begin
                                result.corners.corner_b = IDX_FIELD_W'(older_reg);
                                result.corners.corner_c = IDX_FIELD_W'(newer_reg);
                            end
                            if (prim_mode_reg == MODE_STRIP)
                            begin
                                parity_next = ~parity_reg;
                            end
                            older_next = newer_reg;
                            newer_next = idx;
                        end
                    endcase
                end
            end
            default:
            begin
                // unused mode: drop the index
            end
        endcase

        if (end_of_draw)
        begin
            older_next  = '0;
            newer_next  = '0;
            centre_next = '0;
            count_next  = 2'd0;
            parity_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_reg  <= '0;
            newer_reg  <= '0;
            centre_reg <= '0;
            count_reg  <= 2'd0;
            parity_reg <= 1'b0;
        end
        else if (take)
        begin
            older_reg  <= older_next;
            newer_reg  <= newer_next;
            centre_reg <= centre_next;
            count_reg  <= count_next;
            parity_reg <= parity_next;
        end
    end

endmodule

`default_nettype wire

### hdl/itri_out_stage.sv
`default_nettype none

module itri_out_stage
    import itri_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire result_t push,
    output logic         room,
    output logic         out_valid,
    input  wire logic    out_ready,
    output triangle_t    out_data
);

    logic      out_valid_reg;
    triangle_t out_data_reg;
    logic      skid_valid_reg;
    triangle_t skid_data_reg;
    logic      pop;

    assign room      = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign pop       = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // no push can arrive while the skid slot is full
            if (pop)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push.valid)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push.valid)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_reg <= push.corners;
            end
            else
            begin
                skid_data_reg <= push.corners;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/indexed_triangle_assembler.sv
// A triangle closed by a request is registered in the output register or the skid slot.
// Throughput: one index request per cycle; the output register plus a one-entry skid
// slot keep requests flowing while the triangle sink stalls, until a second triangle waits.
// Reset (rst_n, async, active low): list mode, restart disabled, restart value all ones,
// assembly state cleared, output and skid empty.
`default_nettype none

module indexed_triangle_assembler
    import itri_pkg::*;
#(
    parameter int INDEX_WIDTH = DEF_INDEX_WIDTH
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    itri_index_if.sink                  vertices,
    itri_triangle_if.source             triangles
);

    // Request handshake on the index channel
    logic      room;
    logic      take;
    result_t   assembled;
    triangle_t out_data;

    // Accept whenever the skid slot is free; the output register may still hold a triangle
    assign vertices.ready = room;
    assign take           = vertices.valid && room;

    // Assembly state and configuration; the assembly state advances on every accepted request
    itri_core #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .take         (take),
        .vertex_index (vertices.vertex_index),
        .end_of_draw  (vertices.end_of_draw),
        .result       (assembled)
    );

    // Result register with skid: hold a triangle until the sink takes it
    itri_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (assembled),
        .room      (room),
        .out_valid (triangles.valid),
        .out_ready (triangles.ready),
        .out_data  (out_data)
    );

    assign triangles.corner_a = out_data.corner_a;
    assign triangles.corner_b = out_data.corner_b;
    assign triangles.corner_c = out_data.corner_c;

endmodule

`default_nettype wire

### verif/indexed_triangle_assembler_checker.sv
`timescale 1ns / 1ps

module indexed_triangle_assembler_checker
    import itri_pkg::*;
#(
    parameter int INDEX_WIDTH = DEF_INDEX_WIDTH
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    itri_index_if                       vertices,
    itri_triangle_if                    triangles,
    output int                          fail_count,
    output int                          pending
);

    localparam logic [IDX_FIELD_W-1:0] KEEP_MASK = {IDX_FIELD_W{1'b1}} >> (32 - INDEX_WIDTH);

    // Mirror of the register file
    logic [1:0]             mode_q;
    logic                   restart_en_q;
    logic [IDX_FIELD_W-1:0] restart_val_q;

    // Mirror of the assembly state
    logic [IDX_FIELD_W-1:0] older_q;
    logic [IDX_FIELD_W-1:0] newer_q;
    logic [IDX_FIELD_W-1:0] centre_q;
    logic [1:0]             held_q;
    logic                   odd_q;

    triangle_t expected_triangles[$];

    task automatic clear_assembly();
        older_q  = '0;
        newer_q  = '0;
        centre_q = '0;
        held_q   = 2'd0;
        odd_q    = 1'b0;
    endtask

    // Advance the assembly by one index and queue the triangle it closes, if any.
    task automatic assemble_index(input logic [IDX_FIELD_W-1:0] raw, input logic eod);
        logic [IDX_FIELD_W-1:0] idx;
        triangle_t              made;
        idx = raw & KEEP_MASK;
        case (mode_q)
            MODE_LIST:
            begin
                if (held_q == 2'd0)
                begin
                    older_q = idx;
                    held_q  = 2'd1;
                end
                else if (held_q == 2'd1)
                begin
                    newer_q = idx;
                    held_q  = 2'd2;
                end
                else
                begin
                    made = '{corner_a: older_q, corner_b: newer_q, corner_c: idx};
                    expected_triangles.insert(expected_triangles.size(), made);
                    held_q = 2'd0;
                end
            end
            MODE_STRIP, MODE_FAN:
            begin
                if (restart_en_q && idx == restart_val_q)
                begin
                    held_q = 2'd0;
                    odd_q  = 1'b0;
                end
                else if (held_q == 2'd0)
                begin
                    centre_q = idx;
                    newer_q  = idx;
                    held_q   = 2'd1;
                end
                else if (held_q == 2'd1)
                begin
                    older_q = newer_q;
                    newer_q = idx;
                    held_q  = 2'd2;
                end
                else
                begin
                    if (mode_q == MODE_FAN)
                        made = '{corner_a: idx, corner_b: centre_q, corner_c: newer_q};
                    else if (odd_q)
                        made = '{corner_a: idx, corner_b: newer_q, corner_c: older_q};
                    else
                        made = '{corner_a: idx, corner_b: older_q, corner_c: newer_q};
                    if (mode_q == MODE_STRIP)
                        odd_q = ~odd_q;
                    expected_triangles.insert(expected_triangles.size(), made);
                    older_q = newer_q;
                    newer_q = idx;
                end
            end
            default: ;
        endcase
        if (eod)
            clear_assembly();
    endtask

    task automatic compare_triangle(input triangle_t got);
        triangle_t want;
        if (expected_triangles.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: triangle with none expected: %h %h %h", $realtime,
                         got.corner_a, got.corner_b, got.corner_c);
        end
        else
        begin
            want = expected_triangles.pop_front();
            if (got.corner_a !== want.corner_a || got.corner_b !== want.corner_b ||
                got.corner_c !== want.corner_c)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: triangle mismatch: expected %h %h %h, got %h %h %h",
                             $realtime, want.corner_a, want.corner_b, want.corner_c,
                             got.corner_a, got.corner_b, got.corner_c);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_q        = MODE_LIST;
            restart_en_q  = 1'b0;
            restart_val_q = RESTART_VALUE_RESET;
            clear_assembly();
            expected_triangles.delete();
            fail_count    = 0;
            pending       = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PRIM_MODE:      mode_q = cfg_data[1:0];
                    CFG_RESTART_ENABLE: restart_en_q = cfg_data[0];
                    CFG_RESTART_VALUE:  restart_val_q = cfg_data[IDX_FIELD_W-1:0];
                    default: ;
                endcase
            end
            if (triangles.valid && triangles.ready)
                compare_triangle('{corner_a: triangles.corner_a, corner_b: triangles.corner_b,
                                   corner_c: triangles.corner_c});
            if (vertices.valid && vertices.ready)
                assemble_index(vertices.vertex_index, vertices.end_of_draw);
            pending = expected_triangles.size();
        end
    end

endmodule

### verif/indexed_triangle_assembler_tb.sv
`timescale 1ns / 1ps

module indexed_triangle_assembler_tb;
    import itri_pkg::*;

    // Mode code 3 has no meaning; the block must ignore indices while it is set
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [IDX_FIELD_W-1:0] ALL_ONES = '1;

    // Cycles without any request moving before the run is declared hung
    localparam int STALL_LIMIT = 5000;

    // Random part stops once this many index requests have gone in
    localparam int INDEX_TARGET = 1400;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    itri_index_if    vin();
    itri_triangle_if tout();

    int fail_count;
    int pending;
    int sent_count;
    int quiet_cycles;

    // While set, neither side inserts idle cycles
    bit calm;

    indexed_triangle_assembler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .vertices  (vin),
        .triangles (tout)
    );

    indexed_triangle_assembler_checker tri_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .vertices   (vin),
        .triangles  (tout),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Triangle sink: drop ready at random, about 8 percent of the time, unless calm.
    initial
    begin
        tout.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            tout.ready <= calm || ($urandom_range(0, 99) >= 8);
        end
    end

    // Watchdog: count cycles in which no request moves on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((vin.valid && vin.ready) || (tout.valid && tout.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Offer one index request, with random idle cycles ahead of it, and hold it
    // until the block takes it. Called and returns just after a falling edge.
    task automatic send_index(input logic [IDX_FIELD_W-1:0] idx, input logic eod);
        while (!calm && $urandom_range(0, 99) < 8)
        begin
            vin.valid <= 1'b0;
            @(negedge clk);
        end
        vin.valid        <= 1'b1;
        vin.vertex_index <= idx;
        vin.end_of_draw  <= eod;
        do
            @(posedge clk);
        while (!vin.ready);
        @(negedge clk);
        sent_count++;
    endtask

    // Drop valid and wait until every expected triangle is out, then give the
    // block a few more cycles for indices that close nothing.
    task automatic drain_block();
        vin.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // One register write; only called while the block is drained.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // Restart values: favor small numbers so random indices hit them, plus the extremes.
    function automatic logic [IDX_FIELD_W-1:0] pick_restart();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [IDX_FIELD_W-1:0] pick_index(input logic [IDX_FIELD_W-1:0] rv);
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return rv;
        else if (r < 16)
            return '0;
        else if (r < 20)
            return ALL_ONES;
        else if (r < 50)
            return $urandom_range(0, 15);
        else
            return $urandom;
    endfunction

    initial
    begin
        logic [1:0]             mode_pick;
        logic [IDX_FIELD_W-1:0] rv;
        int                     phase_len;

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        vin.valid        = 1'b0;
        vin.vertex_index = '0;
        vin.end_of_draw  = 1'b0;
        calm             = 1'b0;
        sent_count       = 0;
        quiet_cycles     = 0;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // List mode from reset: extremes of the index, then a partial triangle
        // that end of draw must drop.
        send_index('0, 1'b0);
        send_index(ALL_ONES, 1'b0);
        send_index(32'd1, 1'b0);
        send_index(32'd2, 1'b0);
        send_index(32'd3, 1'b1);

        // Restart enabled in list mode: the restart value is an ordinary index.
        drain_block();
        write_reg(CFG_RESTART_ENABLE, 32'd1);
        send_index(ALL_ONES, 1'b0);
        send_index(32'd4, 1'b0);
        send_index(32'd5, 1'b1);

        // Strip with restart value zero: restart at the first and second
        // positions, even and odd triangles, restart mid strip.
        drain_block();
        write_reg(CFG_PRIM_MODE, {30'd0, MODE_STRIP});
        write_reg(CFG_RESTART_VALUE, '0);
        send_index('0, 1'b0);
        send_index(32'd1, 1'b0);
        send_index('0, 1'b0);
        send_index(32'd1, 1'b0);
        send_index(32'd2, 1'b0);
        send_index(32'd3, 1'b0);
        send_index(32'd4, 1'b0);
        send_index('0, 1'b0);
        send_index(32'd6, 1'b0);
        send_index(32'd7, 1'b0);
        send_index(32'd8, 1'b1);

        // Fan with restart value all ones: centre held, restart at the second position.
        drain_block();
        write_reg(CFG_PRIM_MODE, {30'd0, MODE_FAN});
        write_reg(CFG_RESTART_VALUE, ALL_ONES);
        send_index(32'd10, 1'b0);
        send_index(32'd11, 1'b0);
        send_index(32'd12, 1'b0);
        send_index(ALL_ONES, 1'b0);
        send_index(32'd13, 1'b0);
        send_index(ALL_ONES, 1'b0);
        send_index(32'd14, 1'b0);
        send_index(32'd15, 1'b0);
        send_index(32'd16, 1'b1);

        // Unused mode: indices ignored, end of draw still clears.
        drain_block();
        write_reg(CFG_PRIM_MODE, {30'd0, MODE_UNUSED});
        send_index(32'd9, 1'b0);
        send_index(32'd9, 1'b1);

        // Random phases. A phase may end inside a draw, so the next mode picks
        // up the held state as it stands.
        rv = ALL_ONES;
        while (sent_count < INDEX_TARGET)
        begin
            drain_block();
            calm = (sent_count >= 600 && sent_count < 900);

            case ($urandom_range(0, 15))
                0:        mode_pick = MODE_UNUSED;
                1, 2, 3:  mode_pick = MODE_LIST;
                4, 5, 6,
                7, 8, 9:  mode_pick = MODE_STRIP;
                default:  mode_pick = MODE_FAN;
            endcase
            // Upper data bits are don't-care for the narrow registers
            write_reg(CFG_PRIM_MODE, {30'($urandom_range(0, 32'h3FFF_FFFF)), mode_pick});
            if ($urandom_range(0, 1) == 1)
                write_reg(CFG_RESTART_ENABLE,
                          {31'($urandom_range(0, 32'h7FFF_FFFF)),
                           ($urandom_range(0, 3) != 0)});
            if ($urandom_range(0, 1) == 1)
            begin
                rv = pick_restart();
                write_reg(CFG_RESTART_VALUE, rv);
            end

            phase_len = $urandom_range(40, 140);
            for (int i = 0; i < phase_len; i++)
                send_index(pick_index(rv), ($urandom_range(0, 9) == 0));
        end
        calm = 1'b0;

        // Hold off until every triangle has come back, then a few more cycles
        // to catch a stray one.
        vin.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
hdl/itri_pkg.sv
hdl/itri_if.sv
hdl/itri_core.sv
hdl/itri_out_stage.sv
hdl/indexed_triangle_assembler.sv
verif/indexed_triangle_assembler_checker.sv
verif/indexed_triangle_assembler_tb.sv
